// File: sv/synth_command_stream_validator_defines.svh
// Assertion macros shared by the command stream validator.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef SYNTH_COMMAND_STREAM_VALIDATOR_DEFINES_SVH
`define SYNTH_COMMAND_STREAM_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SCV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SCV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCV_ASSERT_IMP(label, ante, cons, msg)
`define SCV_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: sv/scv_pkg.sv
package scv_pkg;

	localparam int unsigned PhaseW = 3;
	localparam int unsigned LeftW  = 10;

	localparam logic [PhaseW-1:0] PH_OPCODE  = 3'd0;
	localparam logic [PhaseW-1:0] PH_SKIP    = 3'd1;
	localparam logic [PhaseW-1:0] PH_ENVHEAD = 3'd2;
	localparam logic [PhaseW-1:0] PH_HARMC   = 3'd3;
	localparam logic [PhaseW-1:0] PH_WSC     = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_NOVOICE = 2'd3;

	localparam logic [7:0] OP_CLOSE     = 8'h00;
	localparam logic [7:0] OP_SHAPE     = 8'h01;
	localparam logic [7:0] OP_HARMONICS = 8'h02;
	localparam logic [7:0] OP_FM        = 8'h03;
	localparam logic [7:0] OP_FM_LFO    = 8'h04;
	localparam logic [7:0] OP_FREQ      = 8'h05;
	localparam logic [7:0] OP_FREQ_LFO  = 8'h06;
	localparam logic [7:0] OP_LEVEL     = 8'h07;
	localparam logic [7:0] OP_WAVESHAPE = 8'h08;
	localparam logic [7:0] OP_GAIN      = 8'h09;
	localparam logic [7:0] OP_DELAY     = 8'h0a;
	localparam logic [7:0] OP_BANDPASS  = 8'h0e;
	localparam logic [7:0] OP_NOTCH     = 8'h0f;
	localparam logic [7:0] OP_LAST      = 8'h0f;

	localparam logic [7:0] VOICE_MAX = 8'hff;

	typedef struct packed {
		logic       fire;
		logic [1:0] status;
		logic [7:0] voice_count;
	} res_t;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic              err_seen;
		logic [7:0]        voices;
	} core_stat_t;

endpackage

// File: sv/synth_command_stream_validator.sv
// Channel  Dir  Signals                         Contents
// s_*      in   s_tvalid s_tready s_tdata s_tlast  one command byte, tlast on final byte
// m_*      out  m_tvalid m_tready m_tdata          status and voices opened, 0 or 1 per byte
//
// One byte per cycle sustained while no result waits on a full result register; a byte's result
// passes the input register, then the parse step, into the output register.
// Reset clears the parse state and the valid flags of the input and result registers.
// A stalled result blocks only a byte that itself makes a result; bytes that only
// update the parse state keep flowing past a full output register.
// The last byte of a stream returns all parse state to its reset value.
`include "synth_command_stream_validator_defines.svh"

module synth_command_stream_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [9:2] voice_count, [15:10] zero
);

	logic                s1_valid_q;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                can_load;
	logic                adv;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [7:0]          voice_q;
	scv_pkg::res_t       res;
	scv_pkg::core_stat_t stat;

	// the result register can take a new result this cycle
	assign can_load = !out_valid_q || m_tready;
	// advance the held byte unless its result has nowhere to go
	assign adv      = s1_valid_q && (!res.fire || can_load);
	assign s_tready = !s1_valid_q || adv;

	// input register: capture each transfer, drop it once parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	scv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res),
		.stat      (stat)
	);

	// result register: load a fresh result, hold it until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.fire) begin
			status_q <= res.status;
			voice_q  <= res.voice_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, voice_q, status_q};

	`SCV_ASSERT_IMP(a_res_has_room, adv && res.fire, can_load,
		"result overwrote a pending transfer")
	`SCV_ASSERT_NXT(a_last_clears, adv && last_s1,
		stat.phase == scv_pkg::PH_OPCODE && !stat.err_seen && stat.voices == 8'd0,
		"state not cleared after last byte")
	`SCV_ASSERT_NXT(a_err_sticky, adv && stat.err_seen && !last_s1,
		stat.err_seen && !$past(res.fire), "error state lost or result after error")

endmodule

// File: sv/scv_core.sv
module scv_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output scv_pkg::res_t      res,
	output scv_pkg::core_stat_t stat
);

	logic [scv_pkg::PhaseW-1:0] phase_q, phase_d;
	logic [scv_pkg::LeftW-1:0]  left_q, left_d;
	logic                       open_q, open_d;
	logic                       err_q, err_d;
	logic [7:0]                 voices_q, voices_d;
	logic [1:0]                 err_code;
	logic [scv_pkg::LeftW-1:0]  skip_n;
	logic                       skip_go;

	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		open_d   = open_q;
		err_d    = err_q;
		voices_d = voices_q;
		err_code = scv_pkg::ST_OK;
		skip_n   = '0;
		skip_go  = 1'b0;
		res      = '0;

		if (!err_q) begin
			case (phase_q)
				scv_pkg::PH_SKIP: begin
					if (left_q != '0)
						left_d = left_q - 1'b1;
					if (left_q <= scv_pkg::LeftW'(1))
						phase_d = scv_pkg::PH_OPCODE;
				end
				scv_pkg::PH_ENVHEAD: begin
					if (left_q <= scv_pkg::LeftW'(1)) begin
						left_d  = '0;
						skip_n  = {data_byte, 2'b00};
						skip_go = 1'b1;
					end else begin
						left_d = left_q - 1'b1;
					end
				end
				scv_pkg::PH_HARMC: begin
					skip_n  = {1'b0, data_byte, 1'b0};
					skip_go = 1'b1;
				end
				scv_pkg::PH_WSC: begin
					skip_n  = scv_pkg::LeftW'(data_byte) + scv_pkg::LeftW'(2);
					skip_go = 1'b1;
				end
				default: begin
					if (data_byte > scv_pkg::OP_LAST) begin
						err_code = scv_pkg::ST_UNKNOWN;
					end else if (data_byte == scv_pkg::OP_CLOSE) begin
						open_d  = 1'b0;
						phase_d = scv_pkg::PH_OPCODE;
					end else if (data_byte > scv_pkg::OP_FREQ_LFO && !open_q) begin
						err_code = scv_pkg::ST_NOVOICE;
					end else begin
						if (!open_q) begin
							open_d = 1'b1;
							if (voices_q != scv_pkg::VOICE_MAX)
								voices_d = voices_q + 1'b1;
						end
						skip_go = 1'b1;
						case (data_byte)
							scv_pkg::OP_SHAPE: skip_n = scv_pkg::LeftW'(1);
							scv_pkg::OP_HARMONICS: begin
								skip_go = 1'b0;
								phase_d = scv_pkg::PH_HARMC;
							end
							scv_pkg::OP_FM: begin
								skip_go = 1'b0;
								phase_d = scv_pkg::PH_ENVHEAD;
								left_d  = scv_pkg::LeftW'(5);
							end
							scv_pkg::OP_FM_LFO: skip_n = scv_pkg::LeftW'(3);
							scv_pkg::OP_FREQ, scv_pkg::OP_LEVEL: begin
								skip_go = 1'b0;
								phase_d = scv_pkg::PH_ENVHEAD;
								left_d  = scv_pkg::LeftW'(3);
							end
							scv_pkg::OP_WAVESHAPE: begin
								skip_go = 1'b0;
								phase_d = scv_pkg::PH_WSC;
							end
							scv_pkg::OP_FREQ_LFO, scv_pkg::OP_GAIN,
							scv_pkg::OP_BANDPASS, scv_pkg::OP_NOTCH:
								skip_n = scv_pkg::LeftW'(4);
							scv_pkg::OP_DELAY: skip_n = scv_pkg::LeftW'(5);
							default: skip_n = scv_pkg::LeftW'(2);
						endcase
					end
				end
			endcase

			// an empty argument list returns straight to opcode
			if (skip_go) begin
				if (skip_n == '0) begin
					phase_d = scv_pkg::PH_OPCODE;
				end else begin
					phase_d = scv_pkg::PH_SKIP;
					left_d  = skip_n;
				end
			end

			if (err_code != scv_pkg::ST_OK) begin
				res.fire        = 1'b1;
				res.status      = err_code;
				res.voice_count = voices_q;
				err_d           = 1'b1;
			end else if (last_byte) begin
				res.fire        = 1'b1;
				res.status      = (phase_d == scv_pkg::PH_OPCODE) ?
					scv_pkg::ST_OK : scv_pkg::ST_TRUNC;
				res.voice_count = voices_d;
			end
		end

		// the last byte always starts a fresh stream
		if (last_byte) begin
			phase_d  = scv_pkg::PH_OPCODE;
			left_d   = '0;
			open_d   = 1'b0;
			err_d    = 1'b0;
			voices_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scv_pkg::PH_OPCODE;
			left_q   <= '0;
			open_q   <= 1'b0;
			err_q    <= 1'b0;
			voices_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			open_q   <= open_d;
			err_q    <= err_d;
			voices_q <= voices_d;
		end
	end

	assign stat.phase    = phase_q;
	assign stat.err_seen = err_q;
	assign stat.voices   = voices_q;

endmodule
